>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/wepsm_pkg.sv
// ----------------------------------------------------------------------------
// wepsm_pkg
// Types and constants of the wheel edge period speed meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wepsm_pkg;

	localparam int NUM_CHANNELS_DEF = 2;

	localparam int DVD_W = 40;
	localparam int DVS_W = 32;
	localparam int SUM_W = 40;
	localparam int SPD_W = 32;
	localparam int CNT_W = 8;
	localparam int EMP_W = 4;
	localparam int TS_W  = 32;

	localparam logic [SPD_W-1:0] DIST_RESET    = 32'd547498667;
	localparam logic [EMP_W-1:0] TIMEOUT_RESET = 4'd10;
	localparam logic [EMP_W-1:0] EMPTY_MAX     = 4'd15;
	localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic REG_DIST    = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic            command;
		logic            channel;
		logic [TS_W-1:0] timestamp_us;
	} req_t;

	typedef struct packed {
		logic             out_channel;
		logic [CNT_W-1:0] edge_count;
		logic [SPD_W-1:0] speed;
		logic             last;
	} rsp_t;

endpackage

`default_nettype wire

>>> hdl/wepsm_div.sv
// ----------------------------------------------------------------------------
// wepsm_div
// Restoring divider, one quotient bit per cycle, shared by edges and ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module wepsm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wepsm_pkg::DVD_W-1:0]   dividend,
	input  wire logic [wepsm_pkg::DVS_W-1:0]   divisor,
	output logic      [wepsm_pkg::DVD_W-1:0]   quotient,
	output logic                               busy,
	output logic                               done
);

	localparam int DVD_W = wepsm_pkg::DVD_W;
	localparam int DVS_W = wepsm_pkg::DVS_W;
	localparam int CW    = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_nx;
	logic             qbit;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		qbit   = rem_sh >= {1'b0, dvs_q};
		rem_nx = qbit ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= rem_nx[DVS_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

`default_nettype wire

>>> hdl/wheel_edge_period_speed_meter.sv
// ----------------------------------------------------------------------------
// Edge: an edge item runs a 40-step divide of the distance by the interval,
// then the sum update; req_stall is high meanwhile.
// Tick: per channel, the shared divider averages the sum over the edge count
// when the channel saw edges; a channel without edges skips the divide.
// Reset: all channel state cleared, registers at defaults, no clearing pass.
// ----------------------------------------------------------------------------
// wheel_edge_period_speed_meter
// Per-channel period speed meter with averaged, held reports on each tick.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wheel_edge_period_speed_meter #(
	parameter int NUM_CHANNELS = wepsm_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire wepsm_pkg::req_t             req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output wepsm_pkg::rsp_t                  rsp,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_idx,
	input  wire logic [wepsm_pkg::SPD_W-1:0] cfg_data
);

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int REPORTS = (NUM_CHANNELS < 2) ? NUM_CHANNELS : 2;
	localparam int SUM_W   = wepsm_pkg::SUM_W;
	localparam int SPD_W   = wepsm_pkg::SPD_W;
	localparam int CNT_W   = wepsm_pkg::CNT_W;
	localparam int EMP_W   = wepsm_pkg::EMP_W;
	localparam int TS_W    = wepsm_pkg::TS_W;
	localparam int DVD_W   = wepsm_pkg::DVD_W;
	localparam int DVS_W   = wepsm_pkg::DVS_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EDIV   = 3'd1;
	localparam logic [2:0] ST_TSTART = 3'd2;
	localparam logic [2:0] ST_TDIV   = 3'd3;
	localparam logic [2:0] ST_TEMIT  = 3'd4;

	logic [2:0]       state_q;
	logic [CH_W-1:0]  ch_q;
	logic [TS_W-1:0]  stamp_q;
	logic [SPD_W-1:0] dist_q;
	logic [EMP_W-1:0] timeout_q;

	logic [TS_W-1:0]  prev_q  [NUM_CHANNELS];
	logic [CNT_W-1:0] edges_q [NUM_CHANNELS];
	logic [SUM_W-1:0] sum_q   [NUM_CHANNELS];
	logic [EMP_W-1:0] empty_q [NUM_CHANNELS];
	logic [SPD_W-1:0] held_q  [NUM_CHANNELS];

	logic             rsp_valid_q;
	wepsm_pkg::rsp_t  rsp_q;

	logic             acc;
	logic             edge_ok;
	logic [CH_W-1:0]  req_ch;
	logic [TS_W-1:0]  dt_raw;
	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DVD_W-1:0] div_q;
	logic             div_busy;
	logic             div_done;
	logic [SUM_W:0]   sum_add;
	logic [EMP_W-1:0] empty_nx;
	logic [SPD_W-1:0] avg_sat;
	logic             report_en;
	logic             is_last;
	logic             out_free;

	always_comb begin
		acc       = req_valid && !req_stall;
		req_ch    = CH_W'(req.channel);
		edge_ok   = 32'(req.channel) < NUM_CHANNELS;
		dt_raw    = req.timestamp_us - prev_q[req_ch];
		sum_add   = {1'b0, sum_q[ch_q]} + (SUM_W + 1)'(div_q[SPD_W-1:0]);
		empty_nx  = (empty_q[ch_q] == wepsm_pkg::EMPTY_MAX) ? wepsm_pkg::EMPTY_MAX
		            : empty_q[ch_q] + 1'b1;
		avg_sat   = (|div_q[DVD_W-1:SPD_W]) ? '1 : div_q[SPD_W-1:0];
		report_en = {1'b0, ch_q} < (CH_W + 1)'(REPORTS);
		is_last   = ch_q == CH_W'(NUM_CHANNELS - 1);
		out_free  = !rsp_valid_q || !rsp_stall;

		div_start = 1'b0;
		div_dvd   = DVD_W'(dist_q);
		div_dvs   = (dt_raw == '0) ? DVS_W'(1) : dt_raw;
		if (acc && req.command == wepsm_pkg::CMD_EDGE && edge_ok) begin
			div_start = 1'b1;
		end else if (state_q == ST_TSTART && edges_q[ch_q] != '0) begin
			div_start = 1'b1;
			div_dvd   = sum_q[ch_q];
			div_dvs   = DVS_W'(edges_q[ch_q]);
		end
	end

	wepsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_q),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q    <= wepsm_pkg::DIST_RESET;
			timeout_q <= wepsm_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				wepsm_pkg::REG_DIST:    dist_q    <= cfg_data;
				wepsm_pkg::REG_TIMEOUT: timeout_q <= cfg_data[EMP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				prev_q[i]  <= '0;
				edges_q[i] <= '0;
				sum_q[i]   <= '0;
				empty_q[i] <= '0;
				held_q[i]  <= '0;
			end
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (req.command == wepsm_pkg::CMD_TICK) begin
							ch_q    <= '0;
							state_q <= ST_TSTART;
						end else if (edge_ok) begin
							ch_q    <= req_ch;
							state_q <= ST_EDIV;
						end
					end
				end
				ST_EDIV: begin
					if (div_done) begin
						sum_q[ch_q]  <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
						if (edges_q[ch_q] != wepsm_pkg::CNT_MAX) begin
							edges_q[ch_q] <= edges_q[ch_q] + 1'b1;
						end
						prev_q[ch_q] <= stamp_q;
						state_q      <= ST_IDLE;
					end
				end
				ST_TSTART: begin
					if (edges_q[ch_q] == '0) begin
						empty_q[ch_q] <= empty_nx;
						if (empty_nx > timeout_q) begin
							held_q[ch_q] <= '0;
						end
						state_q <= ST_TEMIT;
					end else begin
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						held_q[ch_q]  <= avg_sat;
						empty_q[ch_q] <= '0;
						state_q       <= ST_TEMIT;
					end
				end
				ST_TEMIT: begin
					if (!report_en || out_free) begin
						if (report_en) begin
							rsp_valid_q <= 1'b1;
						end
						edges_q[ch_q] <= '0;
						sum_q[ch_q]   <= '0;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_TSTART;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stamp_q <= req.timestamp_us;
		end
		if (state_q == ST_TEMIT && report_en && out_free) begin
			rsp_q.out_channel <= ch_q[0];
			rsp_q.edge_count  <= edges_q[ch_q];
			rsp_q.speed       <= held_q[ch_q];
			rsp_q.last        <= {1'b0, ch_q} == (CH_W + 1)'(REPORTS - 1);
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_CLK(a_done_in_div, div_done |-> (state_q == ST_EDIV || state_q == ST_TDIV), "divider done outside a divide state")
	`ASSERT_CLK(a_idle_div_free, (state_q == ST_IDLE) |-> !div_busy, "divider busy while idle")
	`ASSERT_CLK(a_rsp_from_emit, $rose(rsp_valid) |-> $past(state_q) == ST_TEMIT, "result raised outside emit")

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Wheel edge period speed meter: directed and random edge/tick items with
// random request gaps and report stalls, each tick's per-channel reports
// checked against an in-bench speed predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int NCH         = wepsm_pkg::NUM_CHANNELS_DEF;
	localparam int DRAIN       = 120;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SPD_W       = wepsm_pkg::SPD_W;
	localparam int EMP_W       = wepsm_pkg::EMP_W;
	localparam int TS_W        = wepsm_pkg::TS_W;
	localparam int CNT_W       = wepsm_pkg::CNT_W;
	localparam int SUM_W       = wepsm_pkg::SUM_W;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	wepsm_pkg::req_t  req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	wepsm_pkg::rsp_t  rsp;
	logic             cfg_we    = 1'b0;
	logic             cfg_idx   = 1'b0;
	logic [SPD_W-1:0] cfg_data  = '0;

	// predictor state
	logic [SPD_W-1:0] dist_cfg;
	logic [EMP_W-1:0] timeout_cfg;
	logic [TS_W-1:0]  last_edge_t [NCH];
	logic [CNT_W-1:0] edges_in_period [NCH];
	logic [SUM_W-1:0] speed_acc [NCH];
	logic [EMP_W-1:0] idle_periods [NCH];
	logic [SPD_W-1:0] held_report [NCH];

	wepsm_pkg::rsp_t  expected_reports [$];
	logic [TS_W-1:0]  stim_stamp [NCH];
	int               err_cnt       = 0;
	int               cycle_cnt     = 0;
	int               rsp_hold_req  = 0;
	bit               req_idle_en   = 1'b0;
	bit               rsp_idle_en   = 1'b0;

	wheel_edge_period_speed_meter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void log_edge(input logic ch, input logic [TS_W-1:0] stamp);
		logic [TS_W-1:0]  dt;
		logic [SPD_W-1:0] sample;
		logic [SUM_W:0]   acc;
		dt = stamp - last_edge_t[ch];
		if (dt == '0) begin
			dt = 1;
		end
		sample = dist_cfg / dt;
		acc = {1'b0, speed_acc[ch]} + sample;
		speed_acc[ch] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
		if (edges_in_period[ch] != wepsm_pkg::CNT_MAX) begin
			edges_in_period[ch]++;
		end
		last_edge_t[ch] = stamp;
	endfunction

	function automatic void report_tick();
		logic [SUM_W-1:0] avg;
		wepsm_pkg::rsp_t  r;
		for (int c = 0; c < NCH; c++) begin
			r.out_channel = c[0];
			r.edge_count  = edges_in_period[c];
			r.last        = (c == NCH - 1);
			if (edges_in_period[c] == '0) begin
				if (idle_periods[c] != wepsm_pkg::EMPTY_MAX) begin
					idle_periods[c]++;
				end
				if (idle_periods[c] > timeout_cfg) begin
					held_report[c] = '0;
				end
			end else begin
				avg = speed_acc[c] / edges_in_period[c];
				held_report[c] = (avg[SUM_W-1:SPD_W] != '0) ? '1 : avg[SPD_W-1:0];
				idle_periods[c] = '0;
			end
			r.speed = held_report[c];
			expected_reports.push_back(r);
		end
		for (int c = 0; c < NCH; c++) begin
			edges_in_period[c] = '0;
			speed_acc[c] = '0;
		end
	endfunction

	task automatic send_item(input wepsm_pkg::req_t item);
		if (req_idle_en && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		if (item.command == wepsm_pkg::CMD_EDGE) begin
			log_edge(item.channel, item.timestamp_us);
		end else begin
			report_tick();
		end
	endtask

	task automatic send_edge(input logic ch, input logic [TS_W-1:0] stamp);
		wepsm_pkg::req_t it;
		it.command = wepsm_pkg::CMD_EDGE;
		it.channel = ch;
		it.timestamp_us = stamp;
		stim_stamp[ch] = stamp;
		send_item(it);
	endtask

	task automatic send_tick();
		wepsm_pkg::req_t it;
		it.command = wepsm_pkg::CMD_TICK;
		it.channel = 1'($urandom_range(0, 1));
		it.timestamp_us = $urandom;
		send_item(it);
	endtask

	// block idle: all reports out and any edge still in the divider finished
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [SPD_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == wepsm_pkg::REG_DIST) begin
			dist_cfg = data;
		end else begin
			timeout_cfg = data[EMP_W-1:0];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		send_edge(1'b0, 32'h0);
		send_edge(1'b0, 32'hFFFF_FFFF);
		send_edge(1'b0, 32'h5);
		send_edge(1'b1, 32'd1000);
		send_tick();
		send_tick();
		send_edge(1'b1, 32'h8000_0000);
		send_edge(1'b1, 32'h8000_0000);
		send_tick();
		send_tick();
		wait_idle();
	endtask

	task automatic test_timeout();
		write_reg(wepsm_pkg::REG_TIMEOUT, 32'd0);
		send_edge(1'b0, stim_stamp[0] + 32'd700);
		send_edge(1'b1, stim_stamp[1] + 32'd900);
		send_tick();
		send_tick();
		send_tick();
		wait_idle();
		write_reg(wepsm_pkg::REG_TIMEOUT, 32'd15);
		send_edge(1'b0, stim_stamp[0] + 32'd650);
		send_edge(1'b1, stim_stamp[1] + 32'd450);
		send_tick();
		repeat (17) send_tick();
		wait_idle();
		write_reg(wepsm_pkg::REG_TIMEOUT, 32'd2);
		send_edge(1'b0, stim_stamp[0] + 32'd300);
		send_tick();
		repeat (4) send_tick();
		wait_idle();
	endtask

	// count, sum and average saturation; then samples that divide to zero
	task automatic test_saturation();
		write_reg(wepsm_pkg::REG_DIST, 32'hFFFF_FFFF);
		req_idle_en = 1'b0;
		for (int i = 0; i < 258; i++) begin
			send_edge(1'b0, stim_stamp[0] + 32'd1);
		end
		repeat (3) send_edge(1'b1, stim_stamp[1]);
		send_tick();
		wait_idle();
		write_reg(wepsm_pkg::REG_DIST, 32'd1);
		req_idle_en = 1'b1;
		send_edge(1'b0, stim_stamp[0] + 32'd12345);
		send_edge(1'b1, stim_stamp[1] + 32'h4000_0000);
		send_tick();
		wait_idle();
		write_reg(wepsm_pkg::REG_DIST, wepsm_pkg::DIST_RESET);
		write_reg(wepsm_pkg::REG_TIMEOUT, SPD_W'(wepsm_pkg::TIMEOUT_RESET));
	endtask

	task automatic test_backpressure();
		req_idle_en = 1'b0;
		rsp_hold_req = 1000;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 3) begin
				send_tick();
			end else begin
				send_edge(i[0], stim_stamp[i[0]] + $urandom_range(100, 9000));
			end
		end
		wait_idle();
	endtask

	task automatic test_random(input int n, input bit idle);
		logic [SPD_W-1:0] d;
		logic             ch;
		int               sel;
		int               sent;
		case ($urandom_range(0, 2))
			0: d = wepsm_pkg::DIST_RESET;
			1: d = $urandom_range(1, 32'h00FF_FFFF);
			default: d = $urandom;
		endcase
		if (d == '0) begin
			d = 1;
		end
		write_reg(wepsm_pkg::REG_DIST, d);
		write_reg(wepsm_pkg::REG_TIMEOUT, $urandom_range(0, 15));
		req_idle_en = idle;
		rsp_idle_en = idle;
		sent = 0;
		while (sent < n) begin
			sel = $urandom_range(0, 99);
			ch = 1'($urandom_range(0, 1));
			if (sel < 2) begin
				repeat ($urandom_range(2, 14)) begin
					send_tick();
					sent++;
				end
			end else if (sel < 14) begin
				send_tick();
				sent++;
			end else begin
				if (sel < 26) begin
					send_edge(ch, $urandom);
				end else if (sel < 38) begin
					send_edge(ch, stim_stamp[ch] + $urandom_range(0, 3));
				end else begin
					send_edge(ch, stim_stamp[ch] + $urandom_range(200, 20000));
				end
				sent++;
			end
		end
		wait_idle();
	endtask

	// report side: random stall bursts, long holds on request, field checks
	initial begin : report_side
		int              stall_left;
		wepsm_pkg::rsp_t exp_r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					$error("report with no expectation: ch %0d cnt %0d speed %h",
						rsp.out_channel, rsp.edge_count, rsp.speed);
					err_cnt++;
				end else begin
					exp_r = expected_reports.pop_front();
					if (rsp.out_channel !== exp_r.out_channel) begin
						$error("out_channel: expected %0d, got %0d",
							exp_r.out_channel, rsp.out_channel);
						err_cnt++;
					end
					if (rsp.edge_count !== exp_r.edge_count) begin
						$error("edge_count: expected %0d, got %0d",
							exp_r.edge_count, rsp.edge_count);
						err_cnt++;
					end
					if (rsp.speed !== exp_r.speed) begin
						$error("speed: expected %h, got %h", exp_r.speed, rsp.speed);
						err_cnt++;
					end
					if (rsp.last !== exp_r.last) begin
						$error("last: expected %0d, got %0d", exp_r.last, rsp.last);
						err_cnt++;
					end
				end
			end
			if (rsp_hold_req != 0) begin
				stall_left = rsp_hold_req;
				rsp_hold_req = 0;
			end else if (stall_left == 0 && rsp_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("wheel_edge_period_speed_meter verification failed");
		$finish;
	end

	initial begin : main
		dist_cfg = wepsm_pkg::DIST_RESET;
		timeout_cfg = wepsm_pkg::TIMEOUT_RESET;
		for (int c = 0; c < NCH; c++) begin
			last_edge_t[c] = '0;
			edges_in_period[c] = '0;
			speed_acc[c] = '0;
			idle_periods[c] = '0;
			held_report[c] = '0;
			stim_stamp[c] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_timeout();
		test_saturation();
		test_backpressure();
		test_random(200, 1'b1);
		test_random(200, 1'b0);
		test_random(200, 1'b1);
		test_random(200, 1'b0);
		if (err_cnt == 0) begin
			$display("wheel_edge_period_speed_meter verification clean");
		end else begin
			$display("wheel_edge_period_speed_meter verification failed");
		end
		$finish;
	end

endmodule
